// ===== src/ctg_pkg.sv =====
// Shared widths, fixed-point constants and helper functions for the circle
// trajectory generator. No dependencies.
`default_nettype none
package ctg_pkg;

  localparam int CORDIC_STEPS_DEF   = 18;
  localparam int TIME_FRAC_BITS_DEF = 32;

  localparam int TIME_W  = 48;
  localparam int Q_W     = 32;
  localparam int TRIG_W  = 34;
  localparam int MUL_A_W = 56;
  localparam int MUL_B_W = 49;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int OUT_W   = 40;
  localparam int EXT_W   = 50;

  localparam logic [31:0] INV_2PI_Q32 = 32'd683565276;
  localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;
  localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [TRIG_W-1:0] ONE_Q30  = 34'sd1073741824;

  typedef logic signed [TRIG_W-1:0] trig_t;

  function automatic trig_t atan_q30(input logic [4:0] i);
    trig_t v;
    case (i)
      5'd0:  v = 34'sh03243F6A8;
      5'd1:  v = 34'sh01DAC6705;
      5'd2:  v = 34'sh00FADBAFC;
      5'd3:  v = 34'sh007F56EA6;
      5'd4:  v = 34'sh003FEAB76;
      5'd5:  v = 34'sh001FFD55B;
      5'd6:  v = 34'sh000FFFAAA;
      5'd7:  v = 34'sh0007FFF55;
      5'd8:  v = 34'sh0003FFFEA;
      5'd9:  v = 34'sh0001FFFFD;
      5'd10: v = 34'sh0000FFFFF;
      5'd11: v = 34'sh00007FFFF;
      5'd12: v = 34'sh00003FFFF;
      5'd13: v = 34'sh00001FFFF;
      5'd14: v = 34'sh00000FFFF;
      5'd15: v = 34'sh000007FFF;
      5'd16: v = 34'sh000003FFF;
      5'd17: v = 34'sh000001FFF;
      5'd18: v = 34'sh000000FFF;
      5'd19: v = 34'sh0000007FF;
      5'd20: v = 34'sh0000003FF;
      5'd21: v = 34'sh0000001FF;
      5'd22: v = 34'sh0000000FF;
      5'd23: v = 34'sh00000007F;
      5'd24: v = 34'sh00000003F;
      5'd25: v = 34'sh00000001F;
      5'd26: v = 34'sh00000000F;
      5'd27: v = 34'sh000000008;
      5'd28: v = 34'sh000000004;
      5'd29: v = 34'sh000000002;
      5'd30: v = 34'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat40(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    logic signed [OUT_W-1:0] r;
    hi = 50'sh00_7FFF_FFFF_FF;
    lo = -50'sh00_8000_0000_00;
    if (v > hi) begin
      r = 40'sh7F_FFFF_FFFF;
    end else if (v < lo) begin
      r = 40'sh80_0000_0000;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/ctg_mul.sv =====
// Bit-serial signed multiplier: one bit of the B operand per cycle.
// Depends on ctg_pkg for operand widths.
`default_nettype none
module ctg_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [ctg_pkg::MUL_A_W-1:0] a,
  input  logic signed [ctg_pkg::MUL_B_W-1:0] b,
  output logic                               done,
  output logic signed [ctg_pkg::MUL_P_W-1:0] prod
);
  import ctg_pkg::*;

  localparam int CW = $clog2(MUL_B_W + 1);

  logic signed [MUL_A_W-1:0] areg;
  logic signed [MUL_A_W:0]   acc;
  logic signed [MUL_A_W:0]   addend;
  logic signed [MUL_A_W:0]   sum;
  logic [MUL_B_W-1:0]        breg;
  logic [CW-1:0]             cnt;
  logic                      busy;
  logic                      last;

  assign last = (cnt == CW'(MUL_B_W - 1));

  always_comb begin
    addend = '0;
    if (breg[0]) begin
      if (last) begin
        addend = -{areg[MUL_A_W-1], areg};
      end else begin
        addend = {areg[MUL_A_W-1], areg};
      end
    end
    sum = acc + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      breg <= b;
      acc  <= '0;
      cnt  <= '0;
    end else if (busy) begin
      acc  <= {sum[MUL_A_W], sum[MUL_A_W:1]};
      breg <= {sum[0], breg[MUL_B_W-1:1]};
      cnt  <= cnt + 1'b1;
    end
  end

  assign prod = {acc[MUL_A_W-1:0], breg};

endmodule
`default_nettype wire

// ===== src/ctg_div.sv =====
// Restoring divider giving a Q0.32 fraction, one quotient bit per cycle.
// Depends on ctg_pkg for widths.
`default_nettype none
module ctg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ctg_pkg::TIME_W-1:0]   num,
  input  logic [ctg_pkg::TIME_W-1:0]   den,
  output logic                         done,
  output logic [ctg_pkg::Q_W-1:0]      quo
);
  import ctg_pkg::*;

  localparam int CW = $clog2(Q_W + 1);

  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dreg;
  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;
  logic              ge;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              last;

  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, dreg};
  assign ge      = (shifted >= {1'b0, dreg});
  assign last    = (cnt == CW'(Q_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dreg <= den;
      quo  <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rem <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      quo <= {quo[Q_W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== src/ctg_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on ctg_pkg for the arctangent table and gain constant.
`default_nettype none
module ctg_cordic #(
  parameter int STEPS = ctg_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ctg_pkg::trig_t z0,
  output logic          done,
  output ctg_pkg::trig_t x,
  output ctg_pkg::trig_t y
);
  import ctg_pkg::*;

  localparam int NS = (STEPS > 32) ? 32 : STEPS;
  localparam int CW = $clog2(NS + 1);

  trig_t         z;
  trig_t         dx;
  trig_t         dy;
  trig_t         at;
  logic [CW-1:0] i;
  logic [4:0]    idx;
  logic          busy;
  logic          last;

  assign idx  = 5'(i);
  assign dx   = y >>> idx;
  assign dy   = x >>> idx;
  assign at   = atan_q30(idx);
  assign last = (i == CW'(NS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= GAIN_Q30;
      y <= '0;
      z <= z0;
      i <= '0;
    end else if (busy) begin
      if (!z[TRIG_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
      i <= i + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== src/circle_trajectory_generator_top.sv =====
// Circle trajectory setpoint generator: sequencer, registers and result staging.
// Depends on ctg_pkg, ctg_mul, ctg_div and ctg_cordic.
//
// Channel  Direction  Beat contents
// s_*      in         tdata[0] restart
// m_*      out        tdata: pos_x, vel_x, acc_x, pos_y, vel_y, acc_y, pos_z, vel_z, acc_z
// cfg_*    in         cfg_index selects the register, cfg_data holds its value
//
// The bit-serial multiplier dominates the time of a tick, from one accepted beat to the next.
// While the ramp is active the divider and two more products add to that time.
// Reset clears the elapsed time, the registers (time_step returns to its default) and all control state.
// A finished result waits in the output register while the next beat is taken.
`default_nettype none
module circle_trajectory_generator_top #(
  parameter int CORDIC_STEPS   = ctg_pkg::CORDIC_STEPS_DEF,
  parameter int TIME_FRAC_BITS = ctg_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [0] restart
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [359:0] m_tdata,   // pos_x, vel_x, acc_x, pos_y, vel_y, acc_y, pos_z, vel_z, acc_z
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ctg_pkg::*;

  localparam int SH  = 16 + TIME_FRAC_BITS;
  localparam int SHL = (TIME_FRAC_BITS >= 32) ? TIME_FRAC_BITS - 32 : 0;
  localparam int SHR = (TIME_FRAC_BITS >= 32) ? 0 : 32 - TIME_FRAC_BITS;

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_CRATE  = 3'd1;
  localparam logic [2:0] REG_LAMP   = 3'd2;
  localparam logic [2:0] REG_LRATE  = 3'd3;
  localparam logic [2:0] REG_STEP   = 3'd4;
  localparam logic [2:0] REG_RAMP   = 3'd5;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MST  = 3'd3;
  localparam logic [2:0] S_MWT  = 3'd4;
  localparam logic [2:0] S_COR  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [4:0] OP_WC  = 5'd0;
  localparam logic [4:0] OP_WL  = 5'd1;
  localparam logic [4:0] OP_IC  = 5'd2;
  localparam logic [4:0] OP_PC  = 5'd3;
  localparam logic [4:0] OP_ZC  = 5'd4;
  localparam logic [4:0] OP_IL  = 5'd5;
  localparam logic [4:0] OP_PL  = 5'd6;
  localparam logic [4:0] OP_ZL  = 5'd7;
  localparam logic [4:0] OP_RW  = 5'd8;
  localparam logic [4:0] OP_RWW = 5'd9;
  localparam logic [4:0] OP_AV  = 5'd10;
  localparam logic [4:0] OP_AVV = 5'd11;
  localparam logic [4:0] OP_PX  = 5'd12;
  localparam logic [4:0] OP_VX  = 5'd13;
  localparam logic [4:0] OP_AX  = 5'd14;
  localparam logic [4:0] OP_PY  = 5'd15;
  localparam logic [4:0] OP_VY  = 5'd16;
  localparam logic [4:0] OP_AY  = 5'd17;
  localparam logic [4:0] OP_PZ  = 5'd18;
  localparam logic [4:0] OP_VZ  = 5'd19;
  localparam logic [4:0] OP_AZ  = 5'd20;

  logic [23:0]        radius;
  logic signed [23:0] circle_rate;
  logic signed [23:0] lift_amplitude;
  logic signed [23:0] lift_rate;
  logic [31:0]        time_step;
  logic [23:0]        ramp_time;

  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W-1:0]  t;
  logic [TIME_W-1:0]  rt;
  logic [TIME_W:0]    step;
  logic [TIME_W:0]    t_sum;
  logic               ramping;

  logic [2:0]         st;
  logic [4:0]         op;

  logic [Q_W-1:0]            f;
  logic signed [23:0]        w_eff;
  logic signed [23:0]        v_eff;
  logic signed [MUL_A_W-1:0] wt;
  logic [31:0]               p;
  logic [31:0]               p_off;
  logic [1:0]                quad;
  logic signed [31:0]        rr;
  logic signed [47:0]        rw;
  logic signed [47:0]        rww;
  logic signed [47:0]        av;
  logic signed [47:0]        avv;
  trig_t                     cc;
  trig_t                     sc;
  trig_t                     ca;
  trig_t                     sa;
  trig_t                     c_new;
  trig_t                     s_new;

  logic signed [OUT_W-1:0] res   [9];
  logic signed [OUT_W-1:0] out_r [9];
  logic [3:0]              res_idx;
  logic signed [47:0]      v48;
  logic signed [EXT_W-1:0] ext;
  logic signed [EXT_W-1:0] res_ext;

  logic                      mul_start;
  logic                      mul_done;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_prod;
  logic                      div_start;
  logic                      div_done;
  logic [Q_W-1:0]            div_q;
  logic                      cor_start;
  logic                      cor_done;
  trig_t                     cor_x;
  trig_t                     cor_y;

  assign cfg_ready = 1'b1;
  assign s_tready  = (st == S_IDLE);

  assign rt      = TIME_W'(ramp_time) << (TIME_FRAC_BITS - 16);
  assign ramping = (ramp_time != '0) && (t < rt);
  assign step    = ((TIME_W + 1)'(time_step) << SHL) >> SHR;
  assign t_sum   = {1'b0, t} + step;

  assign p_off = p + 32'h2000_0000;
  assign quad  = p_off[31:30];
  assign rr    = p - {quad, 30'b0};

  assign mul_start = (st == S_MST);
  assign div_start = (st == S_CHK) && ramping;
  assign cor_start = (st == S_MWT) && mul_done && ((op == OP_ZC) || (op == OP_ZL));

  always_comb begin
    case (op)
      OP_WC:   begin mul_a = MUL_A_W'(circle_rate);    mul_b = MUL_B_W'(f);           end
      OP_WL:   begin mul_a = MUL_A_W'(lift_rate);      mul_b = MUL_B_W'(f);           end
      OP_IC:   begin mul_a = MUL_A_W'(w_eff);          mul_b = MUL_B_W'(INV_2PI_Q32); end
      OP_IL:   begin mul_a = MUL_A_W'(v_eff);          mul_b = MUL_B_W'(INV_2PI_Q32); end
      OP_PC:   begin mul_a = wt;                       mul_b = MUL_B_W'(t);           end
      OP_PL:   begin mul_a = wt;                       mul_b = MUL_B_W'(t);           end
      OP_ZC:   begin mul_a = MUL_A_W'(rr);             mul_b = MUL_B_W'(PI_HALF_Q30); end
      OP_ZL:   begin mul_a = MUL_A_W'(rr);             mul_b = MUL_B_W'(PI_HALF_Q30); end
      OP_RW:   begin mul_a = MUL_A_W'(radius);         mul_b = MUL_B_W'(w_eff);       end
      OP_RWW:  begin mul_a = MUL_A_W'(rw);             mul_b = MUL_B_W'(w_eff);       end
      OP_AV:   begin mul_a = MUL_A_W'(lift_amplitude); mul_b = MUL_B_W'(v_eff);       end
      OP_AVV:  begin mul_a = MUL_A_W'(av);             mul_b = MUL_B_W'(v_eff);       end
      OP_PX:   begin mul_a = MUL_A_W'(radius);         mul_b = MUL_B_W'(cc);          end
      OP_VX:   begin mul_a = MUL_A_W'(rw);             mul_b = MUL_B_W'(sc);          end
      OP_AX:   begin mul_a = MUL_A_W'(rww);            mul_b = MUL_B_W'(cc);          end
      OP_PY:   begin mul_a = MUL_A_W'(radius);         mul_b = MUL_B_W'(sc);          end
      OP_VY:   begin mul_a = MUL_A_W'(rw);             mul_b = MUL_B_W'(cc);          end
      OP_AY:   begin mul_a = MUL_A_W'(rww);            mul_b = MUL_B_W'(sc);          end
      OP_PZ:   begin mul_a = MUL_A_W'(lift_amplitude); mul_b = MUL_B_W'(ONE_Q30 - ca); end
      OP_VZ:   begin mul_a = MUL_A_W'(av);             mul_b = MUL_B_W'(sa);          end
      OP_AZ:   begin mul_a = MUL_A_W'(avv);            mul_b = MUL_B_W'(ca);          end
      default: begin mul_a = '0;                       mul_b = '0;                    end
    endcase
  end

  assign v48     = mul_prod[77:30];
  assign ext     = EXT_W'(v48);
  assign res_idx = 4'(op - OP_PX);

  always_comb begin
    case (op)
      OP_PX:   res_ext = ext - EXT_W'(radius);
      OP_VX:   res_ext = -ext;
      OP_AX:   res_ext = -ext;
      OP_AY:   res_ext = -ext;
      default: res_ext = ext;
    endcase
  end

  always_comb begin
    case (quad)
      2'd0:    begin c_new = cor_x;  s_new = cor_y;  end
      2'd1:    begin c_new = -cor_y; s_new = cor_x;  end
      2'd2:    begin c_new = -cor_x; s_new = -cor_y; end
      default: begin c_new = cor_y;  s_new = -cor_x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius         <= '0;
      circle_rate    <= '0;
      lift_amplitude <= '0;
      lift_rate      <= '0;
      time_step      <= 32'd4294967;
      ramp_time      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIUS: radius         <= cfg_data[23:0];
        REG_CRATE:  circle_rate    <= cfg_data[23:0];
        REG_LAMP:   lift_amplitude <= cfg_data[23:0];
        REG_LRATE:  lift_rate      <= cfg_data[23:0];
        REG_STEP:   time_step      <= cfg_data;
        REG_RAMP:   ramp_time      <= cfg_data[23:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      op       <= OP_WC;
      elapsed  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            st <= S_CHK;
          end
        end
        S_CHK: begin
          if (ramping) begin
            st <= S_DIV;
          end else begin
            op <= OP_IC;
            st <= S_MST;
          end
        end
        S_DIV: begin
          if (div_done) begin
            op <= OP_WC;
            st <= S_MST;
          end
        end
        S_MST: begin
          st <= S_MWT;
        end
        S_MWT: begin
          if (mul_done) begin
            if ((op == OP_ZC) || (op == OP_ZL)) begin
              st <= S_COR;
            end else if (op == OP_AZ) begin
              st <= S_FIN;
            end else begin
              op <= op + 1'b1;
              st <= S_MST;
            end
          end
        end
        S_COR: begin
          if (cor_done) begin
            op <= op + 1'b1;
            st <= S_MST;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            elapsed  <= t_sum[TIME_W] ? {TIME_W{1'b1}} : t_sum[TIME_W-1:0];
            st       <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      t <= s_tdata[0] ? '0 : elapsed;
    end
    if (st == S_CHK && !ramping) begin
      w_eff <= circle_rate;
      v_eff <= lift_rate;
    end
    if (div_done) begin
      f <= div_q;
    end
    if (st == S_COR && cor_done) begin
      if (op == OP_ZC) begin
        cc <= c_new;
        sc <= s_new;
      end else begin
        ca <= c_new;
        sa <= s_new;
      end
    end
    if (st == S_MWT && mul_done) begin
      case (op)
        OP_WC:   w_eff <= mul_prod[55:32];
        OP_WL:   v_eff <= mul_prod[55:32];
        OP_IC:   wt    <= mul_prod[MUL_A_W-1:0];
        OP_IL:   wt    <= mul_prod[MUL_A_W-1:0];
        OP_PC:   p     <= mul_prod[SH+31:SH];
        OP_PL:   p     <= mul_prod[SH+31:SH];
        OP_ZC:   ;
        OP_ZL:   ;
        OP_RW:   rw    <= mul_prod[63:16];
        OP_RWW:  rww   <= mul_prod[63:16];
        OP_AV:   av    <= mul_prod[63:16];
        OP_AVV:  avv   <= mul_prod[63:16];
        default: res[res_idx] <= sat40(res_ext);
      endcase
    end
    if (st == S_FIN && (!m_tvalid || m_tready)) begin
      out_r <= res;
    end
  end

  assign m_tdata = {out_r[8], out_r[7], out_r[6], out_r[5], out_r[4],
                    out_r[3], out_r[2], out_r[1], out_r[0]};

  ctg_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ctg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (t),
    .den   (rt),
    .done  (div_done),
    .quo   (div_q)
  );

  ctg_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .z0    (mul_prod[63:30]),
    .done  (cor_done),
    .x     (cor_x),
    .y     (cor_y)
  );

`ifndef SYNTHESIS
  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (st == S_MWT))
    else $error("Multiplier finished outside its wait state.");

  a_cor_done_state: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> (st == S_COR))
    else $error("CORDIC finished outside its wait state.");

  a_time_hold: assert property (@(posedge clk) disable iff (rst)
    (st != S_FIN) |=> $stable(elapsed))
    else $error("Elapsed time changed outside the end of a tick.");

  a_result_issued: assert property (@(posedge clk) disable iff (rst)
    (st == S_FIN && (!m_tvalid || m_tready)) |=> (m_tvalid && st == S_IDLE))
    else $error("Finished tick did not produce an output beat.");
`endif

endmodule
`default_nettype wire
